>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL, included by the tracker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> rtl/core/drt_pkg.sv
// Types, codes and rectangle helpers for the dirty rectangle tracker.
`timescale 1ns / 1ps

package drt_pkg;

    localparam int EDGE_W      = 13;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [EDGE_W-1:0] edge_t;

    typedef struct packed {
        edge_t left;
        edge_t top;
        edge_t right;
        edge_t bottom;
    } rect_t;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_WHOLE = 2'd1,
        OP_FLUSH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_MERGE = 2'd2,
        CELL_SHIFT = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_ctl_t;

    function automatic logic rect_empty(input rect_t r);
        return (r.right <= r.left) || (r.bottom <= r.top);
    endfunction

    function automatic logic rect_holds(input rect_t outer, input rect_t inner);
        return (outer.left <= inner.left) && (inner.right <= outer.right) &&
               (outer.top <= inner.top) && (inner.bottom <= outer.bottom);
    endfunction

    // Union rules: empty new leaves entry, empty entry takes new, else bounding box.
    function automatic rect_t rect_merge(input rect_t cur, input rect_t nb);
        rect_t res;
        res = cur;
        if (rect_empty(nb)) begin
            res = cur;
        end
        else if (rect_empty(cur)) begin
            res = nb;
        end
        else begin
            res.left   = (nb.left < cur.left) ? nb.left : cur.left;
            res.top    = (nb.top < cur.top) ? nb.top : cur.top;
            res.right  = (nb.right > cur.right) ? nb.right : cur.right;
            res.bottom = (nb.bottom > cur.bottom) ? nb.bottom : cur.bottom;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/drt_cell.sv
// One list cell: holds a rectangle, tests containment, loads, merges or shifts.
`timescale 1ns / 1ps

module drt_cell (
    input  logic              clk,
    input  drt_pkg::cell_ctl_t ctl,
    input  drt_pkg::rect_t    load_rect,
    input  drt_pkg::rect_t    shift_rect,
    input  logic              hit_in,
    output drt_pkg::rect_t    rect,
    output logic              hit_out
);
    import drt_pkg::*;

    rect_t rect_reg;
    rect_t rect_next;

    always_comb
    begin
        case (ctl.op)
            CELL_HOLD:  rect_next = rect_reg;
            CELL_LOAD:  rect_next = load_rect;
            CELL_MERGE: rect_next = rect_merge(rect_reg, load_rect);
            CELL_SHIFT: rect_next = shift_rect;
            default:    rect_next = rect_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
    end

    assign rect    = rect_reg;
    assign hit_out = hit_in | (ctl.occupied & rect_holds(rect_reg, load_rect));

endmodule

>>> rtl/core/dirty_rect_tracker.sv
// Top level of the dirty rectangle tracker: control, cell row and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Dirty rectangle list held in a row of MAX_RECTS cells. An add or whole-frame
// item is registered, then in the execute state every occupied cell tests
// containment in parallel and the target cell loads or merges, unless an add
// is already covered. A flush is registered and decoded, then the row shifts
// toward cell 0 one entry per cycle while the output is not stalled, and
// cell 0 feeds the output register. A new item is taken once the previous
// one has finished; the output register may still hold the last rectangle.
// Cells are not cleared at reset; the entry count, state, output valid and frame size are.
module dirty_rect_tracker #(
    parameter int MAX_RECTS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [drt_pkg::EDGE_W-1:0]          rect_left,
    input  logic [drt_pkg::EDGE_W-1:0]          rect_top,
    input  logic [drt_pkg::EDGE_W-1:0]          rect_right,
    input  logic [drt_pkg::EDGE_W-1:0]          rect_bottom,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [drt_pkg::EDGE_W-1:0]          out_left,
    output logic [drt_pkg::EDGE_W-1:0]          out_top,
    output logic [drt_pkg::EDGE_W-1:0]          out_right,
    output logic [drt_pkg::EDGE_W-1:0]          out_bottom,
    output logic                                out_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [drt_pkg::EDGE_W-1:0]          cfg_data
);
    import drt_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECTS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    op_t              op_reg;
    rect_t            item_rect_reg;
    edge_t            frame_width_reg;
    edge_t            frame_height_reg;
    logic             out_valid_reg, out_valid_next;
    rect_t            out_rect_reg;
    logic             out_last_reg;

    cell_ctl_t        cell_ctl [MAX_RECTS];
    rect_t            cell_rect [MAX_RECTS];
    logic [MAX_RECTS:0] hit_chain;
    rect_t            load_rect;
    logic             in_take;
    logic             out_load;
    logic             hit_any;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_FLUSH) & (~out_valid_reg | ~out_stall);
    assign hit_any   = hit_chain[MAX_RECTS];
    assign hit_chain[0] = 1'b0;

    always_comb
    begin
        if (op_reg == OP_WHOLE) begin
            load_rect = '{left: '0, top: '0,
                          right: frame_width_reg, bottom: frame_height_reg};
        end
        else begin
            load_rect = item_rect_reg;
        end
    end

    // cell row
    for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
        rect_t shift_src;
        if (g == MAX_RECTS - 1) begin : g_tail
            assign shift_src = cell_rect[g];
        end
        else begin : g_body
            assign shift_src = cell_rect[g+1];
        end
        drt_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[g]),
            .load_rect  (load_rect),
            .shift_rect (shift_src),
            .hit_in     (hit_chain[g]),
            .rect       (cell_rect[g]),
            .hit_out    (hit_chain[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        for (int i = 0; i < MAX_RECTS; i++) begin
            cell_ctl[i].op       = CELL_HOLD;
            cell_ctl[i].occupied = (CNT_W'(i) < count_reg);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_take) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!hit_any) begin
                            if (count_reg < CNT_MAX) begin
                                for (int i = 0; i < MAX_RECTS; i++) begin
                                    if (CNT_W'(i) == count_reg) begin
                                        cell_ctl[i].op = CELL_LOAD;
                                    end
                                end
                                count_next = count_reg + CNT_ONE;
                            end
                            else begin
                                cell_ctl[MAX_RECTS-1].op = CELL_MERGE;
                            end
                        end
                    end
                    OP_WHOLE:
                    begin
                        cell_ctl[0].op = CELL_LOAD;
                        count_next     = CNT_ONE;
                    end
                    OP_FLUSH:
                    begin
                        if (count_reg != '0) begin
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FLUSH:
            begin
                if (out_load) begin
                    for (int i = 0; i < MAX_RECTS; i++) begin
                        cell_ctl[i].op = CELL_SHIFT;
                    end
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            frame_width_reg  <= EDGE_W'(640);
            frame_height_reg <= EDGE_W'(480);
        end
        else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) begin
                    frame_width_reg <= cfg_data;
                end
                if (cfg_index == CFG_FRAME_HEIGHT) begin
                    frame_height_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            op_reg        <= op_t'(operation);
            item_rect_reg <= '{left: rect_left, top: rect_top,
                               right: rect_right, bottom: rect_bottom};
        end
        if (out_load) begin
            out_rect_reg <= cell_rect[0];
            out_last_reg <= (count_reg == CNT_ONE);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_rect_reg.left;
    assign out_top    = out_rect_reg.top;
    assign out_right  = out_rect_reg.right;
    assign out_bottom = out_rect_reg.bottom;
    assign out_last   = out_last_reg;

    `ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_MAX)
    `ASSERT_NOW(a_flush_nonempty, state_reg == S_FLUSH, count_reg != '0)
    `ASSERT_NEXT(a_take_exec, in_take, state_reg == S_EXEC)
    `ASSERT_NEXT(a_last_ends, out_load && count_reg == CNT_ONE,
                 state_reg == S_IDLE && count_reg == '0)

endmodule

>>> sim/tb.sv
// Self-checking testbench for dirty_rect_tracker: directed table, then random items.
`timescale 1ns / 1ps

module tb;
    import drt_pkg::*;

    localparam int MAX_RECTS = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int NUM_PHASES = 5;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        rect_t box;
        logic  last;
    } flushed_t;

    typedef struct {
        logic [1:0] op;
        rect_t      box;
        int         typed_n;
        rect_t      typed_box;
    } step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             operation = OP_ADD;
    edge_t                  rect_left = '0;
    edge_t                  rect_top = '0;
    edge_t                  rect_right = '0;
    edge_t                  rect_bottom = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    edge_t                  out_left;
    edge_t                  out_top;
    edge_t                  out_right;
    edge_t                  out_bottom;
    logic                   out_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
    edge_t                  cfg_data = '0;

    // predicted damage list and frame size
    rect_t    damage[MAX_RECTS];
    int       damage_cnt = 0;
    edge_t    frame_w = 13'd640;
    edge_t    frame_h = 13'd480;
    flushed_t pending_rects[$];
    step_t    steps[$];
    flushed_t due;

    int fails = 0;
    int n_items = 0;
    int n_dropped = 0;
    int n_merged = 0;
    int n_flushed_rects = 0;
    int n_settings = 0;
    bit no_idle = 1'b0;
    int stall_left = 0;
    int run_left = 0;

    dirty_rect_tracker #(.MAX_RECTS(MAX_RECTS)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .rect_left  (rect_left),
        .rect_top   (rect_top),
        .rect_right (rect_right),
        .rect_bottom(rect_bottom),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_left   (out_left),
        .out_top    (out_top),
        .out_right  (out_right),
        .out_bottom (out_bottom),
        .out_last   (out_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit box_void(rect_t b);
        return (b.right <= b.left) || (b.bottom <= b.top);
    endfunction

    function automatic bit box_covers(rect_t outer, rect_t inner);
        return (outer.left <= inner.left) && (inner.right <= outer.right) &&
               (outer.top <= inner.top) && (inner.bottom <= outer.bottom);
    endfunction

    // Updates the predicted list; queues flushed rectangles when keep is set.
    function automatic void track_item(logic [1:0] op, rect_t nb, bit keep);
        rect_t    tail;
        bit       held;
        flushed_t f;
        held = 1'b0;
        if (op == OP_ADD)
        begin
            for (int i = 0; i < damage_cnt; i++)
                if (box_covers(damage[i], nb))
                    held = 1'b1;
            if (held)
                n_dropped++;
            else if (damage_cnt < MAX_RECTS)
            begin
                damage[damage_cnt] = nb;
                damage_cnt++;
            end
            else
            begin
                n_merged++;
                tail = damage[MAX_RECTS-1];
                if (box_void(nb))
                    tail = tail;
                else if (box_void(tail))
                    tail = nb;
                else
                begin
                    if (nb.left < tail.left) tail.left = nb.left;
                    if (nb.top < tail.top) tail.top = nb.top;
                    if (nb.right > tail.right) tail.right = nb.right;
                    if (nb.bottom > tail.bottom) tail.bottom = nb.bottom;
                end
                damage[MAX_RECTS-1] = tail;
            end
        end
        else if (op == OP_WHOLE)
        begin
            damage[0].left = '0;
            damage[0].top = '0;
            damage[0].right = frame_w;
            damage[0].bottom = frame_h;
            damage_cnt = 1;
        end
        else if (op == OP_FLUSH)
        begin
            for (int i = 0; i < damage_cnt; i++)
            begin
                f.box = damage[i];
                f.last = (i == damage_cnt - 1);
                if (keep)
                    pending_rects.push_back(f);
            end
            damage_cnt = 0;
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic edge_t edge_pick();
        case ($urandom_range(0, 5))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'd4095;
            3: return 13'd4096;
            4: return 13'd8190;
            default: return 13'd8191;
        endcase
    endfunction

    function automatic rect_t rand_rect();
        rect_t b;
        int    style;
        edge_t tmp;
        style = $urandom_range(0, 19);
        if (style < 10)
        begin
            // small boxes near the origin, so containment and merging happen often
            b.left = edge_t'($urandom_range(0, 56));
            b.top = edge_t'($urandom_range(0, 56));
            b.right = edge_t'(b.left + $urandom_range(0, 14));
            b.bottom = edge_t'(b.top + $urandom_range(0, 14));
            if ($urandom_range(0, 9) == 0)
            begin
                tmp = b.left;
                b.left = b.right;
                b.right = tmp;
            end
        end
        else if (style < 15)
        begin
            b.left = edge_t'($urandom_range(0, 4000));
            b.top = edge_t'($urandom_range(0, 4000));
            b.right = edge_t'(b.left + $urandom_range(0, 1000));
            b.bottom = edge_t'(b.top + $urandom_range(0, 1000));
        end
        else if (style < 18)
        begin
            b.left = edge_t'($urandom_range(0, 8191));
            b.top = edge_t'($urandom_range(0, 8191));
            b.right = edge_t'($urandom_range(0, 8191));
            b.bottom = edge_t'($urandom_range(0, 8191));
        end
        else
        begin
            b.left = edge_pick();
            b.top = edge_pick();
            b.right = edge_pick();
            b.bottom = edge_pick();
        end
        return b;
    endfunction

    function automatic logic [1:0] pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return OP_ADD;
        if (k < 77)
            return OP_WHOLE;
        if (k < 95)
            return OP_FLUSH;
        return OP_UNUSED;
    endfunction

    function automatic void add_row(logic [1:0] op, int l, int t, int r, int b,
                                    int typed_n, int tl, int tt, int tr, int tb);
        step_t s;
        s.op = op;
        s.box.left = edge_t'(l);
        s.box.top = edge_t'(t);
        s.box.right = edge_t'(r);
        s.box.bottom = edge_t'(b);
        s.typed_n = typed_n;
        s.typed_box.left = edge_t'(tl);
        s.typed_box.top = edge_t'(tt);
        s.typed_box.right = edge_t'(tr);
        s.typed_box.bottom = edge_t'(tb);
        steps.push_back(s);
    endfunction

    function automatic void check_field(string name, edge_t want, edge_t got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(input step_t s);
        int       gap;
        flushed_t f;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = s.op;
        rect_left = s.box.left;
        rect_top = s.box.top;
        rect_right = s.box.right;
        rect_bottom = s.box.bottom;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (s.op != OP_UNUSED)
            n_items++;
        track_item(s.op, s.box, s.typed_n < 0);
        if (s.typed_n > 0)
        begin
            f.box = s.typed_box;
            f.last = 1'b1;
            pending_rects.push_back(f);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input edge_t val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_FRAME_WIDTH)
            frame_w = val;
        else
            frame_h = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (pending_rects.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (no_idle)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (run_left > 0)
        begin
            out_stall <= 1'b0;
            run_left <= run_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            run_left <= $urandom_range(0, 8);
            stall_left <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rects.size() == 0)
            begin
                $error("unexpected rectangle %0d,%0d,%0d,%0d last=%0d",
                       out_left, out_top, out_right, out_bottom, out_last);
                fails++;
            end
            else
            begin
                due = pending_rects.pop_front();
                check_field("out_left", due.box.left, out_left);
                check_field("out_top", due.box.top, out_top);
                check_field("out_right", due.box.right, out_right);
                check_field("out_bottom", due.box.bottom, out_bottom);
                check_field("out_last", edge_t'(due.last), edge_t'(out_last));
                n_flushed_rects++;
            end
        end
    end

    initial
    begin
        step_t row;
        int    sent;
        edge_t phase_w[NUM_PHASES];
        edge_t phase_h[NUM_PHASES];
        phase_w = '{13'd1, 13'd4096, 13'd0, 13'd0, 13'd8191};
        phase_h = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd0};

        add_row(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_WHOLE, 0, 0, 0, 0, -1, 0, 0, 0, 0);
        add_row(OP_FLUSH, 0, 0, 0, 0, 1, 0, 0, 640, 480);
        add_row(OP_ADD, 0, 0, 0, 0, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 8191, 8191, 8191, 8191, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 0, 0, 8191, 8191, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 10, 10, 20, 20, -1, 0, 0, 0, 0);
        add_row(OP_UNUSED, 5, 5, 5, 5, -1, 0, 0, 0, 0);
        add_row(OP_FLUSH, 0, 0, 0, 0, -1, 0, 0, 0, 0);
        for (int i = 0; i < 7; i++)
            add_row(OP_ADD, i * 16, 0, i * 16 + 8, 8, -1, 0, 0, 0, 0);
        // empty box lands in the last slot, then gets replaced
        add_row(OP_ADD, 300, 300, 200, 200, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 500, 500, 600, 600, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 8000, 8000, 8100, 7000, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 700, 650, 800, 900, -1, 0, 0, 0, 0);
        add_row(OP_FLUSH, 0, 0, 0, 0, -1, 0, 0, 0, 0);
        add_row(OP_ADD, 8191, 0, 0, 8191, -1, 0, 0, 0, 0);
        add_row(OP_WHOLE, 0, 0, 0, 0, -1, 0, 0, 0, 0);
        add_row(OP_FLUSH, 0, 0, 0, 0, -1, 0, 0, 0, 0);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (steps[i])
            send_item(steps[i]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            no_idle = (p == 2);
            if (p == 3)
            begin
                phase_w[p] = edge_t'($urandom_range(1, 4096));
                phase_h[p] = edge_t'($urandom_range(1, 4096));
            end
            write_reg(CFG_FRAME_WIDTH, phase_w[p]);
            write_reg(CFG_FRAME_HEIGHT, phase_h[p]);
            n_settings++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                row.op = pick_op();
                row.box = rand_rect();
                row.typed_n = -1;
                row.typed_box = '0;
                if (row.op != OP_UNUSED)
                    sent++;
                send_item(row);
            end
        end

        settle();
        repeat (20) @(negedge clk);
        $display("Run covered %0d items under %0d frame sizes besides the default;",
                 n_items, n_settings);
        $display("%0d adds dropped as covered, %0d merged into a full list, %0d rects flushed.",
                 n_dropped, n_merged, n_flushed_rects);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $error("timeout: run did not drain");
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/drt_pkg.sv
rtl/core/drt_cell.sv
rtl/core/dirty_rect_tracker.sv
sim/tb.sv
